// ===== sv/minv3_pkg.sv =====
// Shared types and fixed widths for the 3x3 adjugate matrix inverse.
// No dependencies; the interface, divider, top and testbench files import this package.
package minv3_pkg;

    localparam int ELEM_W  = 16;
    localparam int ELEM_FR = 12;
    localparam int OUT_W   = 32;
    localparam int OUT_FR  = 16;
    localparam int LANES   = 9;

    localparam int FRAC_SH = ELEM_FR + OUT_FR;
    localparam int PRE_SH  = OUT_W - FRAC_SH;
    localparam int COF_W   = 2 * ELEM_W + 1;
    localparam int PROD_W  = ELEM_W + COF_W;
    localparam int DET_W   = PROD_W + 2;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [OUT_W-1:0]  t_res;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic [COF_W-1:0]         t_num;
    typedef logic [DET_W-1:0]         t_den;
    typedef logic [OUT_W-1:0]         t_quo;
    typedef logic [PRE_SH-1:0]        t_nlo;

    typedef struct packed {
        logic             singular;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] pre_over;
    } t_div_tag;

endpackage

// ===== sv/minv3_if.sv =====
// Handshake channels of the matrix inverse: the input matrix and the result.
// Depends on minv3_pkg for the element and result types.
interface minv3_mat_if;
    import minv3_pkg::*;
    logic  valid;
    logic  ready;
    t_elem a_0_0, a_0_1, a_0_2, a_1_0, a_1_1, a_1_2, a_2_0, a_2_1, a_2_2;
    modport source (output valid, a_0_0, a_0_1, a_0_2, a_1_0, a_1_1, a_1_2,
                    a_2_0, a_2_1, a_2_2, input ready);
    modport sink   (input valid, a_0_0, a_0_1, a_0_2, a_1_0, a_1_1, a_1_2,
                    a_2_0, a_2_1, a_2_2, output ready);
endinterface

interface minv3_inv_if;
    import minv3_pkg::*;
    logic valid;
    logic ready;
    t_res inv_0_0, inv_0_1, inv_0_2, inv_1_0, inv_1_1, inv_1_2, inv_2_0, inv_2_1, inv_2_2;
    logic singular;
    logic saturated;
    modport source (output valid, inv_0_0, inv_0_1, inv_0_2, inv_1_0, inv_1_1, inv_1_2,
                    inv_2_0, inv_2_1, inv_2_2, singular, saturated, input ready);
    modport sink   (input valid, inv_0_0, inv_0_1, inv_0_2, inv_1_0, inv_1_1, inv_1_2,
                    inv_2_0, inv_2_1, inv_2_2, singular, saturated, output ready);
endinterface

// ===== sv/minv3_div.sv =====
// Pipelined restoring divider array: nine quotients sharing one divisor, one bit per stage.
// Depends on minv3_pkg.
module minv3_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  minv3_pkg::t_den     i_den,
    input  minv3_pkg::t_den     i_rem0 [minv3_pkg::LANES],
    input  minv3_pkg::t_nlo     i_nlo  [minv3_pkg::LANES],
    input  minv3_pkg::t_div_tag i_tag,
    output logic                o_vld,
    input  logic                i_rdy,
    output minv3_pkg::t_quo     o_quo  [minv3_pkg::LANES],
    output minv3_pkg::t_div_tag o_tag
);
    import minv3_pkg::*;

    logic [OUT_W-1:0] r_v;
    logic [OUT_W:0]   en;
    t_den             r_den [OUT_W];
    t_div_tag         r_tag [OUT_W];
    t_den             r_rem [OUT_W][LANES];
    t_quo             r_q   [OUT_W][LANES];
    t_nlo             r_nlo [OUT_W][LANES];

    always_comb begin
        en[OUT_W] = i_rdy;
        for (int k = OUT_W - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    for (genvar k = 0; k < OUT_W; k++) begin : g_st
        logic     w_vin;
        t_den     w_d;
        t_div_tag w_tag;

        if (k == 0) begin : g_first
            assign w_vin = i_vld;
            assign w_d   = i_den;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_vin = r_v[k-1];
            assign w_d   = r_den[k-1];
            assign w_tag = r_tag[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_den[k] <= w_d;
                r_tag[k] <= w_tag;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_ln
            t_den         w_rp;
            t_nlo         w_nl;
            t_quo         w_qp;
            logic [DET_W:0] w_t;
            logic         w_ge;

            if (k == 0) begin : g_first
                assign w_rp = i_rem0[l];
                assign w_nl = i_nlo[l];
                assign w_qp = '0;
            end else begin : g_next
                assign w_rp = r_rem[k-1][l];
                assign w_nl = r_nlo[k-1][l];
                assign w_qp = r_q[k-1][l];
            end

            assign w_t  = {w_rp, w_nl[PRE_SH-1]};
            assign w_ge = w_t >= {1'b0, w_d};

            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_rem[k][l] <= w_ge ? DET_W'(w_t - {1'b0, w_d}) : w_t[DET_W-1:0];
                    r_nlo[k][l] <= w_nl << 1;
                    r_q[k][l]   <= {w_qp[OUT_W-2:0], w_ge};
                end
            end
        end
    end

    assign o_rdy = en[0];
    assign o_vld = r_v[OUT_W-1];
    assign o_tag = r_tag[OUT_W-1];

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_q[OUT_W-1][l];

        // A lane that did not overflow must end with a remainder below the divisor.
        a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (o_vld && !o_tag.singular && !o_tag.pre_over[l])
            |-> (r_rem[OUT_W-1][l] < r_den[OUT_W-1]))
            else $error("divider remainder not below divisor");
    end

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> (r_v == '0))
        else $error("divider valid bits survive reset");

    a_empty_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> o_rdy)
        else $error("divider refuses a transfer with an empty first stage");

endmodule

// ===== sv/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse by the adjugate method. A matrix of nine signed Q4.12 elements is
// accepted in every cycle unless the pipeline is full, and its inverse leaves as nine
// signed Q16.16 elements, each the transposed cofactor times 2^28 divided by the exact
// determinant, truncated toward zero and saturated to 32 bits. A zero determinant gives
// all zeros with singular set. Data passes six front stages (input register, cofactors,
// products, determinant, magnitudes, divider set-up), 32 stages of the bit-per-stage
// divider array, and the output register. Stalls hold every stage in place, and bubbles
// are squeezed out, so the block keeps taking matrices until all 39 stages are full.
module matrix_inverse_3x3 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    minv3_mat_if.sink   i_mat,
    minv3_inv_if.source o_inv
);
    import minv3_pkg::*;

    localparam int NF = 6;

    function automatic t_cof f_cross(t_elem x, t_elem y, t_elem z, t_elem w);
        logic signed [2*ELEM_W-1:0] p;
        logic signed [2*ELEM_W-1:0] q;
        p = x * y;
        q = z * w;
        return COF_W'(p) - COF_W'(q);
    endfunction

    t_elem    w_a [LANES];
    logic [NF-1:0] r_v;
    logic [NF:0]   en;
    logic     div_rdy;
    logic     div_vld;
    logic     en_o;
    t_quo     div_quo [LANES];
    t_div_tag div_tag;

    t_elem    r1_a    [LANES];
    t_cof     r2_cof  [LANES];
    t_elem    r2_m    [3];
    t_prod    r3_p    [3];
    t_cof     r3_cof  [LANES];
    t_det     r4_det;
    t_cof     r4_cof  [LANES];
    t_num     r5_num  [LANES];
    t_den     r5_den;
    logic [LANES-1:0] r5_neg;
    logic     r5_sing;
    t_den     r6_den;
    t_den     r6_rem0 [LANES];
    t_nlo     r6_nlo  [LANES];
    t_div_tag r6_tag;
    t_den     w_dabs;

    logic     r_ov;
    t_res     r_inv   [LANES];
    logic     r_sing;
    logic     r_sat;
    t_res     n_inv   [LANES];
    logic     n_sat;

    assign w_a[0] = i_mat.a_0_0;
    assign w_a[1] = i_mat.a_0_1;
    assign w_a[2] = i_mat.a_0_2;
    assign w_a[3] = i_mat.a_1_0;
    assign w_a[4] = i_mat.a_1_1;
    assign w_a[5] = i_mat.a_1_2;
    assign w_a[6] = i_mat.a_2_0;
    assign w_a[7] = i_mat.a_2_1;
    assign w_a[8] = i_mat.a_2_2;

    always_comb begin
        en[NF] = div_rdy;
        for (int k = NF - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_mat.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_mat.valid;
            end
            for (int k = 1; k < NF; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_a <= w_a;
        end
        if (en[1]) begin
            r2_cof[0] <= f_cross(r1_a[4], r1_a[8], r1_a[5], r1_a[7]);
            r2_cof[1] <= f_cross(r1_a[2], r1_a[7], r1_a[1], r1_a[8]);
            r2_cof[2] <= f_cross(r1_a[1], r1_a[5], r1_a[2], r1_a[4]);
            r2_cof[3] <= f_cross(r1_a[5], r1_a[6], r1_a[3], r1_a[8]);
            r2_cof[4] <= f_cross(r1_a[0], r1_a[8], r1_a[2], r1_a[6]);
            r2_cof[5] <= f_cross(r1_a[2], r1_a[3], r1_a[0], r1_a[5]);
            r2_cof[6] <= f_cross(r1_a[3], r1_a[7], r1_a[4], r1_a[6]);
            r2_cof[7] <= f_cross(r1_a[1], r1_a[6], r1_a[0], r1_a[7]);
            r2_cof[8] <= f_cross(r1_a[0], r1_a[4], r1_a[1], r1_a[3]);
            r2_m[0]   <= r1_a[0];
            r2_m[1]   <= r1_a[3];
            r2_m[2]   <= r1_a[6];
        end
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_p[i] <= r2_m[i] * r2_cof[i];
            end
            r3_cof <= r2_cof;
        end
        if (en[3]) begin
            r4_det <= DET_W'(r3_p[0]) + DET_W'(r3_p[1]) + DET_W'(r3_p[2]);
            r4_cof <= r3_cof;
        end
        if (en[4]) begin
            r5_sing <= (r4_det == '0);
            r5_den  <= w_dabs;
            for (int l = 0; l < LANES; l++) begin
                r5_neg[l] <= r4_cof[l][COF_W-1] ^ r4_det[DET_W-1];
                r5_num[l] <= r4_cof[l][COF_W-1] ? COF_W'(-r4_cof[l]) : COF_W'(r4_cof[l]);
            end
        end
        if (en[5]) begin
            r6_den          <= r5_den;
            r6_tag.singular <= r5_sing;
            r6_tag.neg      <= r5_neg;
            for (int l = 0; l < LANES; l++) begin
                r6_tag.pre_over[l] <= (DET_W + PRE_SH)'(r5_num[l])
                                      >= {r5_den, PRE_SH'(0)};
                r6_rem0[l] <= DET_W'(r5_num[l] >> PRE_SH);
                r6_nlo[l]  <= r5_num[l][PRE_SH-1:0];
            end
        end
    end

    assign w_dabs = r4_det[DET_W-1] ? DET_W'(-r4_det) : DET_W'(r4_det);

    minv3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v[NF-1]),
        .o_rdy   (div_rdy),
        .i_den   (r6_den),
        .i_rem0  (r6_rem0),
        .i_nlo   (r6_nlo),
        .i_tag   (r6_tag),
        .o_vld   (div_vld),
        .i_rdy   (en_o),
        .o_quo   (div_quo),
        .o_tag   (div_tag)
    );

    assign en_o = !r_ov || o_inv.ready;

    always_comb begin
        logic [OUT_W:0] lim;
        logic [OUT_W:0] mag;
        logic           over;
        n_sat = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            lim  = div_tag.neg[l] ? {2'b01, {(OUT_W-1){1'b0}}}
                                  : {2'b00, {(OUT_W-1){1'b1}}};
            over = div_tag.pre_over[l] || ({1'b0, div_quo[l]} > lim);
            mag  = over ? lim : {1'b0, div_quo[l]};
            n_inv[l] = div_tag.neg[l] ? OUT_W'(-mag) : OUT_W'(mag);
            n_sat    = n_sat || over;
            if (div_tag.singular) begin
                n_inv[l] = '0;
            end
        end
        if (div_tag.singular) begin
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_inv  <= n_inv;
            r_sing <= div_tag.singular;
            r_sat  <= n_sat;
        end
    end

    assign o_inv.valid     = r_ov;
    assign o_inv.inv_0_0   = r_inv[0];
    assign o_inv.inv_0_1   = r_inv[1];
    assign o_inv.inv_0_2   = r_inv[2];
    assign o_inv.inv_1_0   = r_inv[3];
    assign o_inv.inv_1_1   = r_inv[4];
    assign o_inv.inv_1_2   = r_inv[5];
    assign o_inv.inv_2_0   = r_inv[6];
    assign o_inv.inv_2_1   = r_inv[7];
    assign o_inv.inv_2_2   = r_inv[8];
    assign o_inv.singular  = r_sing;
    assign o_inv.saturated = r_sat;

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_inv.valid && (r_v == '0))
        else $error("valid bits survive reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_mat.ready |-> (&r_v))
        else $error("input refused while a front stage is empty");

    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_inv.valid && o_inv.singular)
        |-> (!o_inv.saturated && o_inv.inv_0_0 == '0 && o_inv.inv_1_1 == '0
             && o_inv.inv_2_2 == '0))
        else $error("singular result carries data or saturation");

endmodule

// ===== dv/minv3_scoreboard.sv =====
// Scoreboard for the 3x3 matrix inverse: computes the expected inverse of each accepted
// matrix and checks results in order.
`timescale 1ns / 100ps

class minv3_scoreboard;
    typedef struct {
        logic signed [31:0] inv[9];
        logic               singular;
        logic               saturated;
    } t_inverse;

    t_inverse pending_inverses[$];
    int       mismatches;

    function new();
        mismatches = 0;
    endfunction

    static function logic signed [31:0] scaled_quotient(longint num, longint den, ref bit sat);
        bit          neg;
        longint unsigned n, d, lim, q, r;
        bit          over;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        q = n / d;
        r = n % d;
        over = q > lim;
        for (int k = 0; k < 28 && !over; k++) begin
            q = q << 1;
            if (r >= d - r) begin
                r = r - (d - r);
                q = q | 1;
            end else begin
                r = r + r;
            end
            if (q > lim) over = 1;
        end
        if (over) begin
            sat = 1;
            q = lim;
        end
        return neg ? -q : q;
    endfunction

    function void note_matrix(logic signed [15:0] a[9]);
        longint   m[3][3];
        longint   c[9];
        longint   det;
        bit       sat;
        t_inverse e;
        sat = 0;
        for (int i = 0; i < 9; i++) m[i/3][i%3] = a[i];
        c[0] = m[1][1]*m[2][2] - m[1][2]*m[2][1];
        c[1] = -(m[0][1]*m[2][2] - m[0][2]*m[2][1]);
        c[2] = m[0][1]*m[1][2] - m[0][2]*m[1][1];
        c[3] = -(m[1][0]*m[2][2] - m[1][2]*m[2][0]);
        c[4] = m[0][0]*m[2][2] - m[0][2]*m[2][0];
        c[5] = -(m[0][0]*m[1][2] - m[0][2]*m[1][0]);
        c[6] = m[1][0]*m[2][1] - m[1][1]*m[2][0];
        c[7] = -(m[0][0]*m[2][1] - m[0][1]*m[2][0]);
        c[8] = m[0][0]*m[1][1] - m[0][1]*m[1][0];
        det = m[0][0]*c[0] + m[1][0]*c[1] + m[2][0]*c[2];
        if (det == 0) begin
            for (int i = 0; i < 9; i++) e.inv[i] = 0;
            e.singular = 1;
            e.saturated = 0;
        end else begin
            for (int i = 0; i < 9; i++) e.inv[i] = scaled_quotient(c[i], det, sat);
            e.singular = 0;
            e.saturated = sat;
        end
        pending_inverses.push_back(e);
    endfunction

    function void check_inverse(logic signed [31:0] got[9], logic sing, logic sat);
        t_inverse e;
        bit       bad;
        if (pending_inverses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transfer at %0t", $time);
            return;
        end
        e = pending_inverses.pop_front();
        bad = (sing !== e.singular) || (sat !== e.saturated);
        for (int i = 0; i < 9; i++) if (got[i] !== e.inv[i]) bad = 1;
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch at %0t: singular %0d/%0d saturated %0d/%0d",
                         $time, e.singular, sing, e.saturated, sat);
                for (int i = 0; i < 9; i++)
                    $display("  inv[%0d] expected %0d actual %0d", i, e.inv[i], got[i]);
            end
        end
    endfunction
endclass

// ===== dv/tb.sv =====
// Testbench top for matrix_inverse_3x3: drives directed and random matrices with random
// idling and back-pressure. Depends on minv3_pkg, minv3_if and minv3_scoreboard.
`timescale 1ns / 100ps

module tb;
    import minv3_pkg::*;

    logic i_clk;
    logic i_rst_n;
    minv3_mat_if mat_ch ();
    minv3_inv_if inv_ch ();
    minv3_scoreboard inverses = new();

    longint cycle_count;
    int     hold_off_cycles;
    bit     calm;

    matrix_inverse_3x3 u_top (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_mat(mat_ch), .o_inv(inv_ch));

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("matrix_inverse_3x3 verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        logic signed [15:0] a[9];
        logic signed [31:0] r[9];
        if (i_rst_n && mat_ch.valid && mat_ch.ready) begin
            a = '{mat_ch.a_0_0, mat_ch.a_0_1, mat_ch.a_0_2, mat_ch.a_1_0, mat_ch.a_1_1,
                  mat_ch.a_1_2, mat_ch.a_2_0, mat_ch.a_2_1, mat_ch.a_2_2};
            inverses.note_matrix(a);
        end
        if (i_rst_n && inv_ch.valid && inv_ch.ready) begin
            r = '{inv_ch.inv_0_0, inv_ch.inv_0_1, inv_ch.inv_0_2, inv_ch.inv_1_0,
                  inv_ch.inv_1_1, inv_ch.inv_1_2, inv_ch.inv_2_0, inv_ch.inv_2_1,
                  inv_ch.inv_2_2};
            inverses.check_inverse(r, inv_ch.singular, inv_ch.saturated);
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            inv_ch.ready <= 0;
        end else begin
            inv_ch.ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    task automatic send_matrix(logic signed [15:0] a[9]);
        while (!calm && $urandom_range(99) < 32) begin
            mat_ch.valid <= 0;
            @(negedge i_clk);
        end
        mat_ch.valid <= 1;
        {mat_ch.a_0_0, mat_ch.a_0_1, mat_ch.a_0_2} <= {a[0], a[1], a[2]};
        {mat_ch.a_1_0, mat_ch.a_1_1, mat_ch.a_1_2} <= {a[3], a[4], a[5]};
        {mat_ch.a_2_0, mat_ch.a_2_1, mat_ch.a_2_2} <= {a[6], a[7], a[8]};
        do @(posedge i_clk); while (!mat_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] random_elem();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return $urandom_range(1) ? 16'sh1000 : -16'sh1000;
            2: return $signed(16'($urandom_range(15))) - 8;
            3: return $signed(16'($urandom_range(8191))) - 4096;
            default: return $signed(16'($urandom));
        endcase
    endfunction

    task automatic send_random_matrix();
        logic signed [15:0] a[9];
        int                 pick;
        for (int i = 0; i < 9; i++) a[i] = random_elem();
        pick = $urandom_range(9);
        if (pick == 0) for (int j = 0; j < 3; j++) a[3 + j] = a[j];
        else if (pick == 1) for (int j = 0; j < 3; j++) a[3*j + 1] = 0;
        else if (pick == 2) begin
            for (int i = 0; i < 9; i++) a[i] = 0;
            a[0] = $signed(16'($urandom_range(3))) - 1;
            a[4] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            a[8] = random_elem();
        end
        send_matrix(a);
    endtask

    task automatic wait_drained();
        mat_ch.valid <= 0;
        while (inverses.pending_inverses.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic signed [15:0] a[9];
        cycle_count = 0;
        hold_off_cycles = 0;
        calm = 0;
        i_rst_n = 0;
        mat_ch.valid = 0;
        {mat_ch.a_0_0, mat_ch.a_0_1, mat_ch.a_0_2, mat_ch.a_1_0, mat_ch.a_1_1,
         mat_ch.a_1_2, mat_ch.a_2_0, mat_ch.a_2_1, mat_ch.a_2_2} = '0;
        inv_ch.ready = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        a = '{16'sh1000, 0, 0, 0, 16'sh1000, 0, 0, 0, 16'sh1000};
        send_matrix(a);
        a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(a);
        a = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_matrix(a);
        a = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        send_matrix(a);
        a = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
        send_matrix(a);
        a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(a);
        a = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(a);
        a = '{16'sh8000, 16'sh7FFF, 0, 16'sh7FFF, 16'sh8000, 0, 0, 0, -1};
        send_matrix(a);
        a = '{0, 16'sh1000, 0, 16'sh1000, 0, 0, 0, 0, 16'sh1000};
        send_matrix(a);
        a = '{16'sh2000, 16'sh1000, 16'sh0800, -16'sh1000, 16'sh3000, 16'sh0400,
              16'sh0100, -16'sh0200, 16'sh1000};
        send_matrix(a);
        a = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh7FFF};
        send_matrix(a);
        a = '{3, 1, 0, 1, 3, 0, 0, 0, 16'sh7FFF};
        send_matrix(a);

        for (int n = 0; n < 1500; n++) begin
            if (n == 300) begin
                wait_drained();
                repeat (20) @(negedge i_clk);
            end
            if (n == 500) hold_off_cycles = 150;
            if (n == 800) calm = 1;
            if (n == 1000) calm = 0;
            send_random_matrix();
        end
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (inverses.mismatches == 0 && inverses.pending_inverses.size() == 0) begin
            $display("matrix_inverse_3x3 verification clean");
        end else begin
            $display("matrix_inverse_3x3 verification failed");
        end
        $finish;
    end
endmodule
